### rtl/isotp_rx_pkg.sv
`default_nettype none

package isotp_rx_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_ERROR  = 3'd1,
        ST_SENDFC = 3'd2,
        ST_INPROG = 3'd3,
        ST_DONE   = 3'd4
    } status_t;

    // PCI frame types (upper nibble of byte 0)
    localparam logic [3:0] PCI_SINGLE      = 4'd0;
    localparam logic [3:0] PCI_FIRST       = 4'd1;
    localparam logic [3:0] PCI_CONSECUTIVE = 4'd2;

    localparam logic [3:0]  SF_MAX_LEN  = 4'd7;
    localparam logic [2:0]  CF_MAX_LEN  = 3'd7;
    localparam logic [2:0]  FF_DATA_LEN = 3'd6;
    localparam logic [11:0] FF_MIN_LEN  = 12'd8;

    // One CAN frame
    typedef struct packed {
        logic [3:0]  frame_len;
        logic [63:0] frame_bytes;
    } in_item_t;

    // One reassembly result
    typedef struct packed {
        status_t     status;
        logic [11:0] write_index;
        logic [2:0]  write_count;
        logic [55:0] payload_bytes;
        logic [11:0] message_length;
    } out_item_t;

    // Reassembly context carried between frames
    typedef struct packed {
        logic [11:0] message_length;
        logic [11:0] bytes_received;
        logic [3:0]  expected_sequence;
        logic        transfer_active;
    } rx_state_t;

    // Keep the first n bytes of a 56-bit packed payload, zero the rest
    function automatic logic [55:0] keep_bytes(input logic [55:0] p, input logic [2:0] n);
        logic [55:0] r;
        r = '0;
        for (int i = 0; i < 7; i++) begin
            if (3'(i) < n) begin
                r[55 - 8*i -: 8] = p[55 - 8*i -: 8];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/isotp_rx_decode.sv
`default_nettype none

// Frame decode: classifies one frame against the current context and
// produces the result plus the updated context.
module isotp_rx_decode (
    input  wire isotp_rx_pkg::in_item_t  frame,
    input  wire isotp_rx_pkg::rx_state_t cur,
    input  wire logic [11:0]             capacity,
    output isotp_rx_pkg::out_item_t      result,
    output isotp_rx_pkg::rx_state_t      nxt
);
    import isotp_rx_pkg::*;

    logic [7:0]  b0;
    logic [3:0]  pci;
    logic [3:0]  low;
    logic [55:0] data56;
    logic [11:0] ff_len;
    logic [11:0] avail;
    logic [2:0]  cf_cnt;
    logic [11:0] br_sum;
    logic        sf_bad;
    logic        ff_bad;

    assign b0     = frame.frame_bytes[63:56];
    assign pci    = b0[7:4];
    assign low    = b0[3:0];
    assign data56 = frame.frame_bytes[55:0];
    assign ff_len = {low, frame.frame_bytes[55:48]};

    assign sf_bad = (low == 4'd0) || (low > SF_MAX_LEN) || ({8'd0, low} > capacity);
    assign ff_bad = (ff_len < FF_MIN_LEN) || (ff_len > capacity);

    // Bytes still owed, clipped to one consecutive frame
    assign avail  = (cur.bytes_received < cur.message_length)
                    ? (cur.message_length - cur.bytes_received) : 12'd0;
    assign cf_cnt = (avail < {9'd0, CF_MAX_LEN}) ? avail[2:0] : CF_MAX_LEN;
    assign br_sum = cur.bytes_received + {9'd0, cf_cnt};

    always_comb
    begin
        result = '{status: ST_IDLE, write_index: '0, write_count: '0,
                   payload_bytes: '0, message_length: '0};
        nxt    = cur;
        if (frame.frame_len != 4'd0) begin
            unique case (pci)
                PCI_SINGLE:
                begin
                    if (sf_bad) begin
                        result.status = ST_ERROR;
                    end else begin
                        result.status         = ST_DONE;
                        result.write_count    = low[2:0];
                        result.payload_bytes  = keep_bytes(data56, low[2:0]);
                        result.message_length = {8'd0, low};
                        nxt.message_length    = {8'd0, low};
                        nxt.bytes_received    = {8'd0, low};
                        nxt.transfer_active   = 1'b0;
                    end
                end
                PCI_FIRST:
                begin
                    if (ff_bad) begin
                        result.status = ST_ERROR;
                    end else begin
                        result.status         = ST_SENDFC;
                        result.write_count    = FF_DATA_LEN;
                        result.payload_bytes  = {frame.frame_bytes[47:0], 8'h00};
                        result.message_length = ff_len;
                        nxt.message_length    = ff_len;
                        nxt.bytes_received    = {9'd0, FF_DATA_LEN};
                        nxt.expected_sequence = 4'd1;
                        nxt.transfer_active   = 1'b1;
                    end
                end
                PCI_CONSECUTIVE:
                begin
                    if (!cur.transfer_active) begin
                        result.status = ST_IDLE;
                    end else if (low != cur.expected_sequence) begin
                        result.status       = ST_ERROR;
                        nxt.transfer_active = 1'b0;
                    end else begin
                        result.write_index    = cur.bytes_received;
                        result.write_count    = cf_cnt;
                        result.payload_bytes  = keep_bytes(data56, cf_cnt);
                        result.message_length = cur.message_length;
                        nxt.bytes_received    = br_sum;
                        nxt.expected_sequence = cur.expected_sequence + 4'd1;
                        if (br_sum >= cur.message_length) begin
                            result.status       = ST_DONE;
                            nxt.transfer_active = 1'b0;
                        end else begin
                            result.status = ST_INPROG;
                        end
                    end
                end
                default:
                begin
                    // flow control and unknown types are ignored
                    result.status = ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/isotp_rx_reassembler_unit.sv
`default_nettype none

// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | in_data   (frame_len, frame_bytes)
// out     | output    | out_valid / out_stall| out_data  (status .. message_length)
// cfg     | input     | cfg_valid / cfg_ready| cfg_data  (buffer_capacity, 12 bit)
//
// Path: input register, decode, result register; a frame waits in the input register
// while the result register is stalled. One frame per cycle while the output is not stalled.
// The reassembly context updates in the cycle a frame moves into the result register.
// Reset clears the context (expected sequence set to 1), sets capacity to 4095 and empties both stages.
// A stalled output holds its result; the input stalls only when both stages are
// full and the output is stalled.
module isotp_rx_reassembler_unit (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire isotp_rx_pkg::in_item_t  in_data,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output isotp_rx_pkg::out_item_t      out_data,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [11:0]             cfg_data
);
    import isotp_rx_pkg::*;

    logic      s1_valid_reg;
    in_item_t  s1_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    rx_state_t state_reg;
    rx_state_t state_next;
    out_item_t result;
    logic [11:0] capacity_reg;
    logic      advance;
    logic      in_xfer;

    // Pipeline control
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity_reg <= 12'd4095;
        end else if (cfg_valid && cfg_ready) begin
            capacity_reg <= cfg_data;
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            s1_data_reg <= in_data;
        end
    end

    isotp_rx_decode u_decode (
        .frame    (s1_data_reg),
        .cur      (state_reg),
        .capacity (capacity_reg),
        .result   (result),
        .nxt      (state_next)
    );

    // Reassembly context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '{message_length: '0, bytes_received: '0,
                           expected_sequence: 4'd1, transfer_active: 1'b0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

`ifndef ASSERT_OFF
    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.status == ST_IDLE || out_data_reg.status == ST_ERROR)
        |-> out_data_reg.write_count == 3'd0 && out_data_reg.payload_bytes == 56'd0
            && out_data_reg.message_length == 12'd0 && out_data_reg.write_index == 12'd0)
        else $error("idle or error result carries data");

    a_active_short: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.transfer_active |-> state_reg.bytes_received < state_reg.message_length)
        else $error("active transfer already complete");

    a_done_fills: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status == ST_DONE
        |-> out_data_reg.write_index + 12'(out_data_reg.write_count)
            == out_data_reg.message_length)
        else $error("done result does not end at message length");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room available");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> capacity_reg == $past(cfg_data))
        else $error("capacity write lost");
`endif

endmodule

`default_nettype wire
